[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the indexed bank mapper.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AST_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define AST_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/ibm_pkg.sv]
// Package for the indexed bank mapper: codes, config and queue entry types.
// No dependencies; imported by every module of the block but ibm_fifo.
`default_nettype none

package ibm_pkg;

  localparam int NUM_BANK_REGS  = 8;
  localparam int CHR_BANK_BITS  = 9;
  localparam int SLOT_BITS      = 3;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 9;
  localparam int MID_DEPTH_DEF  = 2;
  localparam int OUT_DEPTH_DEF  = 2;

  // Address decode
  localparam logic [15:0] WIN_LO     = 16'h4100;
  localparam logic [15:0] WIN_HI     = 16'h7FFF;
  localparam logic [15:0] PORT_MASK  = 16'h0101;
  localparam logic [15:0] PORT_INDEX = 16'h0100;
  localparam logic [15:0] PORT_DATA  = 16'h0101;

  // Special bank register slots
  localparam logic [SLOT_BITS-1:0] SLOT_PRG    = 3'd5;
  localparam logic [SLOT_BITS-1:0] SLOT_MIRROR = 3'd7;

  // Config register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_BOARD_VARIANT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRG_BANK_MAX   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRG_SWITCH_EN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHR_2K_MAX     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHR_1K_MAX     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHR_IS_RAM     = 3'd5;

  typedef enum logic [1:0] {
    VAR_A = 2'd0,
    VAR_B = 2'd1,
    VAR_C = 2'd2,
    VAR_D = 2'd3
  } variant_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_PRG    = 2'd1,
    OP_MIRROR = 2'd2,
    OP_CHR    = 2'd3
  } op_t;

  typedef struct packed {
    variant_t   board_variant;
    logic [7:0] prg_bank_max;
    logic       prg_switch_enabled;
    logic [7:0] chr_2k_bank_max;
    logic [8:0] chr_1k_bank_max;
    logic       chr_is_ram;
  } cfg_t;

  typedef logic [CHR_BANK_BITS-1:0] chr_bank_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic                 accepted;
    op_t                  op;
    logic [7:0]           data;
    chr_bank_t [3:0]      chr_raw;
  } cmd_t;

  // Result entry: mapping after the request
  typedef struct packed {
    logic                 accepted;
    logic [7:0]           prg_bank;
    chr_bank_t [3:0]      chr_bank;
    logic [1:0]           mirror_mode;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/ibm_fifo.sv]
// Small register queue used between mapper stages.
// Depends on nothing but its parameters.
`default_nettype none

module ibm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ibm_front.sv]
// Front end: address decode, index/bank register file, raw CHR bank math.
// Depends on ibm_pkg.
`default_nettype none

module ibm_front
  import ibm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        accept,
  input  wire logic [15:0] bus_address,
  input  wire logic [7:0]  write_data,
  output cmd_t             cmd
);

  logic [SLOT_BITS-1:0] index_r, index_nxt;
  logic [7:0]           bank_r [NUM_BANK_REGS];
  logic [7:0]           regs_v [NUM_BANK_REGS];
  logic                 in_window, hit_index, hit_data;
  logic [15:0]          port;
  chr_bank_t [3:0]      chr_raw;

  assign in_window = (bus_address >= WIN_LO) && (bus_address <= WIN_HI);
  assign port      = bus_address & PORT_MASK;
  assign hit_index = in_window && (port == PORT_INDEX);
  assign hit_data  = in_window && (port == PORT_DATA);
  assign index_nxt = hit_index ? write_data[SLOT_BITS-1:0] : index_r;

  // Bank register view including this request's write
  always_comb begin
    for (int i = 0; i < NUM_BANK_REGS; i++) begin
      regs_v[i] = (hit_data && (index_r == SLOT_BITS'(i))) ? write_data : bank_r[i];
    end
  end

  // Raw (unclamped) CHR banks
  always_comb begin
    logic [2:0] low;
    logic [5:0] base;
    logic [7:0] shifted;
    logic [7:0] ors;
    logic       same;
    chr_raw = '0;
    low     = '0;
    base    = '0;
    shifted = '0;
    ors     = '0;
    same = regs_v[7][0];
    if (cfg.board_variant == VAR_D) begin
      chr_raw[0] = CHR_BANK_BITS'({regs_v[0][2:0]});
      chr_raw[1] = CHR_BANK_BITS'({regs_v[4][0], 1'b0, regs_v[1][2:0]});
      chr_raw[2] = CHR_BANK_BITS'({regs_v[4][1], 1'b0, regs_v[2][2:0]});
      chr_raw[3] = CHR_BANK_BITS'({regs_v[4][2], regs_v[6][0], regs_v[3][2:0]});
    end else begin
      for (int k = 0; k < 4; k++) begin
        low  = (same || k == 0) ? regs_v[0][2:0] : regs_v[k][2:0];
        base = {regs_v[4][2:0], low};
        case (cfg.board_variant)
          VAR_A:   begin
            shifted = {1'b0, base, 1'b0};
            ors     = (k == 1 || k == 3) ? 8'd1 : 8'd0;
          end
          VAR_B:   begin
            shifted = {2'b00, base};
            ors     = 8'd0;
          end
          default: begin
            shifted = {base, 2'b00};
            ors     = 8'(k);
          end
        endcase
        chr_raw[k] = CHR_BANK_BITS'(shifted | ors);
      end
    end
  end

  always_comb begin
    cmd.accepted = hit_index || hit_data;
    cmd.data     = write_data;
    cmd.chr_raw  = chr_raw;
    cmd.op       = OP_NONE;
    if (hit_data) begin
      if (index_r == SLOT_PRG) begin
        cmd.op = OP_PRG;
      end else if (index_r == SLOT_MIRROR) begin
        cmd.op = OP_MIRROR;
      end else begin
        cmd.op = OP_CHR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      for (int i = 0; i < NUM_BANK_REGS; i++) begin
        bank_r[i] <= '0;
      end
    end else if (accept) begin
      index_r <= index_nxt;
      for (int i = 0; i < NUM_BANK_REGS; i++) begin
        bank_r[i] <= regs_v[i];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ibm_back.sv]
// Back end: clamps and applies classified requests to the live mapping.
// Depends on ibm_pkg.
`default_nettype none

module ibm_back
  import ibm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic take,
  input  wire cmd_t cmd,
  output res_t      res
);

  logic [7:0]      prg_r, prg_nxt;
  chr_bank_t [3:0] chr_r, chr_nxt;
  logic [1:0]      mirror_r, mirror_nxt;
  chr_bank_t       chr_max;

  assign chr_max = (cfg.board_variant == VAR_D) ? cfg.chr_1k_bank_max
                                                : CHR_BANK_BITS'(cfg.chr_2k_bank_max);

  always_comb begin
    prg_nxt    = prg_r;
    chr_nxt    = chr_r;
    mirror_nxt = mirror_r;
    case (cmd.op)
      OP_PRG: begin
        if (cfg.prg_switch_enabled) begin
          prg_nxt = (cmd.data > cfg.prg_bank_max) ? (cmd.data & cfg.prg_bank_max) : cmd.data;
        end
      end
      OP_MIRROR: begin
        mirror_nxt = cmd.data[0] ? 2'd0 : cmd.data[2:1];
      end
      OP_CHR: begin
        if (!cfg.chr_is_ram) begin
          for (int k = 0; k < 4; k++) begin
            chr_nxt[k] = (cmd.chr_raw[k] > chr_max) ? (cmd.chr_raw[k] & chr_max)
                                                    : cmd.chr_raw[k];
          end
        end
      end
      default: ;
    endcase
  end

  assign res.accepted    = cmd.accepted;
  assign res.prg_bank    = prg_nxt;
  assign res.chr_bank    = chr_nxt;
  assign res.mirror_mode = mirror_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_r    <= '0;
      chr_r    <= '0;
      mirror_r <= '0;
    end else if (take) begin
      prg_r    <= prg_nxt;
      chr_r    <= chr_nxt;
      mirror_r <= mirror_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/indexed_bank_mapper_8259.sv]
// Indexed bank mapper top level: config registers, front, back, two queues.
// Depends on ibm_pkg, ibm_fifo, ibm_front, ibm_back and assert_macros.svh.
//
// One request is one CPU write (address, byte); one result comes back per
// request, carrying the hit flag and the full mapping after that write.
// Up to one request per cycle: the front decodes and updates the index and
// bank registers in the cycle it takes a request and queues a classified
// command; the back clamps and applies it once it leaves the command queue
// and queues the result. Input stalls (in_full) only when the command queue
// is full, i.e. when results are not being popped. Configuration writes land
// immediately and are meant to happen with no request in flight.
`default_nettype none
`include "assert_macros.svh"

module indexed_bank_mapper_8259
  import ibm_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request queue side
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic [15:0]              in_bus_address,
  input  wire logic [7:0]               in_write_data,
  // result queue side
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic                          out_write_accepted,
  output logic [7:0]                    out_prg_bank,
  output logic [CHR_BANK_BITS-1:0]      out_chr_bank_a,
  output logic [CHR_BANK_BITS-1:0]      out_chr_bank_b,
  output logic [CHR_BANK_BITS-1:0]      out_chr_bank_c,
  output logic [CHR_BANK_BITS-1:0]      out_chr_bank_d,
  output logic [1:0]                    out_mirror_mode,
  // config write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  cmd_t front_cmd, mid_cmd;
  res_t back_res, out_res;
  logic in_accept;
  logic mid_full, mid_empty, mid_pop;
  logic out_full;

  // Config registers; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOARD_VARIANT: cfg_nxt.board_variant      = variant_t'(cfg_data[1:0]);
        CFG_PRG_BANK_MAX:  cfg_nxt.prg_bank_max       = cfg_data[7:0];
        CFG_PRG_SWITCH_EN: cfg_nxt.prg_switch_enabled = cfg_data[0];
        CFG_CHR_2K_MAX:    cfg_nxt.chr_2k_bank_max    = cfg_data[7:0];
        CFG_CHR_1K_MAX:    cfg_nxt.chr_1k_bank_max    = cfg_data[8:0];
        CFG_CHR_IS_RAM:    cfg_nxt.chr_is_ram         = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.board_variant      <= VAR_A;
      cfg_r.prg_bank_max       <= 8'd0;
      cfg_r.prg_switch_enabled <= 1'b1;
      cfg_r.chr_2k_bank_max    <= 8'hFF;
      cfg_r.chr_1k_bank_max    <= 9'h1FF;
      cfg_r.chr_is_ram         <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: takes a request whenever the command queue has room
  assign in_full   = mid_full;
  assign in_accept = in_push && !mid_full;

  ibm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (in_accept),
    .bus_address (in_bus_address),
    .write_data  (in_write_data),
    .cmd         (front_cmd)
  );

  ibm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (front_cmd),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_cmd),
    .empty     (mid_empty)
  );

  // Back: drains one command per cycle while the result queue has room
  assign mid_pop = !mid_empty && !out_full;

  ibm_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .take  (mid_pop),
    .cmd   (mid_cmd),
    .res   (back_res)
  );

  ibm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_pop),
    .push_data (back_res),
    .full      (out_full),
    .pop       (out_pop),
    .pop_data  (out_res),
    .empty     (out_empty)
  );

  assign out_write_accepted = out_res.accepted;
  assign out_prg_bank       = out_res.prg_bank;
  assign out_chr_bank_a     = out_res.chr_bank[0];
  assign out_chr_bank_b     = out_res.chr_bank[1];
  assign out_chr_bank_c     = out_res.chr_bank[2];
  assign out_chr_bank_d     = out_res.chr_bank[3];
  assign out_mirror_mode    = out_res.mirror_mode;

  // Back never sits idle with work queued and room downstream
  `AST_IMPL(a_back_drains, clk, rst_n, !mid_empty && !out_full, mid_pop)
  // A taken request is held in one of the queues in the cycle after it is taken
  `AST_NEXT(a_req_held, clk, rst_n, in_accept, !mid_empty || !out_empty)
  // An empty command queue means nothing moves to the result queue
  `AST_IMPL(a_no_phantom, clk, rst_n, mid_empty, !mid_pop)

endmodule

`default_nettype wire

[bench/indexed_bank_mapper_8259_test.sv]
// Testbench for indexed_bank_mapper_8259: CPU writes in, one mapping result per write out.
// Depends on ibm_pkg and the mapper RTL. It predicts each mapping itself and checks
// every result in order, across several configuration settings.

module indexed_bank_mapper_8259_test;
  import ibm_pkg::*;

  localparam logic [1:0] MIRROR_VERTICAL = 2'd0;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int LAST_PHASE = 8;
  localparam int STEADY_PHASE = 4;

  // Keeps its own copy of the mapper state and of the config registers, works out
  // the mapping after every accepted request and compares results in order.
  class mapping_scoreboard;
    variant_t   variant;
    logic [7:0] prg_max;
    logic       prg_switch;
    logic [7:0] chr2k_max;
    logic [8:0] chr1k_max;
    logic       chr_ram;

    logic [2:0] index_sel;
    logic [7:0] bank_reg [NUM_BANK_REGS];
    logic [7:0] prg_now;
    chr_bank_t  chr_now [4];
    logic [1:0] mirror_now;

    res_t expected_maps [$];
    int   mismatches;
    int   results_seen;

    function new();
      variant    = VAR_A;
      prg_max    = 8'd0;
      prg_switch = 1'b1;
      chr2k_max  = 8'hFF;
      chr1k_max  = 9'h1FF;
      chr_ram    = 1'b0;
      index_sel  = 3'd0;
      foreach (bank_reg[i]) bank_reg[i] = 8'd0;
      prg_now    = 8'd0;
      foreach (chr_now[i]) chr_now[i] = '0;
      mirror_now = MIRROR_VERTICAL;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] value);
      case (idx)
        CFG_BOARD_VARIANT: variant    = variant_t'(value[1:0]);
        CFG_PRG_BANK_MAX:  prg_max    = value[7:0];
        CFG_PRG_SWITCH_EN: prg_switch = value[0];
        CFG_CHR_2K_MAX:    chr2k_max  = value[7:0];
        CFG_CHR_1K_MAX:    chr1k_max  = value[8:0];
        CFG_CHR_IS_RAM:    chr_ram    = value[0];
        default: ;
      endcase
    endfunction

    // over the limit: AND with it; at or under: unchanged
    function int clamp(int v, int limit);
      return (v > limit) ? (v & limit) : v;
    endfunction

    function void remap_chr();
      int v [4];
      int r4;
      int high;
      int shift_by;
      int or_bits [4];
      int src;
      bit same;
      r4 = int'(bank_reg[4]);
      if (variant == VAR_D) begin
        // 1K banks: reg4 bits 0..2 and reg6 bit 0 feed the upper bits
        v[0] = bank_reg[0] & 7;
        v[1] = (bank_reg[1] & 7) | ((r4 << 4) & 'h10);
        v[2] = (bank_reg[2] & 7) | ((r4 << 3) & 'h10);
        v[3] = (bank_reg[3] & 7) | ((r4 << 2) & 'h10) | ((int'(bank_reg[6]) << 3) & 'h08);
        for (int k = 0; k < 4; k++) chr_now[k] = chr_bank_t'(clamp(v[k], chr1k_max));
      end else begin
        high = (r4 << 3) & 'h38;
        same = bank_reg[7][0];
        case (variant)
          VAR_A: begin
            shift_by = 1;
            or_bits = '{0, 1, 0, 1};
          end
          VAR_B: begin
            shift_by = 0;
            or_bits = '{0, 0, 0, 0};
          end
          default: begin
            shift_by = 2;
            or_bits = '{0, 1, 2, 3};
          end
        endcase
        for (int k = 0; k < 4; k++) begin
          src  = (same || k == 0) ? 0 : k;
          v[k] = (((high | (bank_reg[src] & 7)) << shift_by) | or_bits[k]) & 'hFF;
          chr_now[k] = chr_bank_t'(clamp(v[k], chr2k_max));
        end
      end
    endfunction

    function void note_request(logic [15:0] addr, logic [7:0] data);
      res_t map;
      logic [15:0] port;
      map.accepted = 1'b0;
      if (addr >= WIN_LO && addr <= WIN_HI) begin
        port = addr & PORT_MASK;
        if (port == PORT_INDEX) begin
          index_sel    = data[2:0];
          map.accepted = 1'b1;
        end else if (port == PORT_DATA) begin
          map.accepted        = 1'b1;
          bank_reg[index_sel] = data;
          if (index_sel == SLOT_PRG) begin
            if (prg_switch) prg_now = 8'(clamp(data, prg_max));
          end else if (index_sel == SLOT_MIRROR) begin
            mirror_now = data[0] ? MIRROR_VERTICAL : data[2:1];
          end else if (!chr_ram) begin
            remap_chr();
          end
        end
      end
      map.prg_bank = prg_now;
      for (int k = 0; k < 4; k++) map.chr_bank[k] = chr_now[k];
      map.mirror_mode = mirror_now;
      expected_maps.push_back(map);
    endfunction

    function void compare(string field, logic [8:0] want, logic [8:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(res_t seen);
      res_t want;
      results_seen++;
      if (expected_maps.size() == 0) begin
        $error("mapping result popped with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_maps.pop_front();
      compare("write_accepted", want.accepted, seen.accepted);
      compare("prg_bank", want.prg_bank, seen.prg_bank);
      compare("chr_bank_a", want.chr_bank[0], seen.chr_bank[0]);
      compare("chr_bank_b", want.chr_bank[1], seen.chr_bank[1]);
      compare("chr_bank_c", want.chr_bank[2], seen.chr_bank[2]);
      compare("chr_bank_d", want.chr_bank[3], seen.chr_bank[3]);
      compare("mirror_mode", want.mirror_mode, seen.mirror_mode);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_bus_address = 16'h0000;
  logic [7:0]  in_write_data = 8'h00;

  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic                     out_write_accepted;
  logic [7:0]               out_prg_bank;
  logic [CHR_BANK_BITS-1:0] out_chr_bank_a;
  logic [CHR_BANK_BITS-1:0] out_chr_bank_b;
  logic [CHR_BANK_BITS-1:0] out_chr_bank_c;
  logic [CHR_BANK_BITS-1:0] out_chr_bank_d;
  logic [1:0]               out_mirror_mode;

  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // steady: neither side idles (one whole phase runs at full rate)
  bit steady = 1'b0;
  int requests_sent = 0;
  mapping_scoreboard sb;

  indexed_bank_mapper_8259 dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_bus_address     (in_bus_address),
    .in_write_data      (in_write_data),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_write_accepted (out_write_accepted),
    .out_prg_bank       (out_prg_bank),
    .out_chr_bank_a     (out_chr_bank_a),
    .out_chr_bank_b     (out_chr_bank_b),
    .out_chr_bank_c     (out_chr_bank_c),
    .out_chr_bank_d     (out_chr_bank_d),
    .out_mirror_mode    (out_mirror_mode),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #10 clk = ~clk;

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: values are sampled right at the edge, before the block's own
  // updates land, so a pop seen here is exactly the one the block takes.
  always @(posedge clk) begin : result_side
    res_t got;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && out_empty === 1'b0) begin
        got.accepted    = out_write_accepted;
        got.prg_bank    = out_prg_bank;
        got.chr_bank[0] = out_chr_bank_a;
        got.chr_bank[1] = out_chr_bank_b;
        got.chr_bank[2] = out_chr_bank_c;
        got.chr_bank[3] = out_chr_bank_d;
        got.mirror_mode = out_mirror_mode;
        sb.check_result(got);
      end
      // stall about 15 percent of the time, except in the steady phase
      out_pop <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  // Push one request and hold it until the block takes it. The gap is counted
  // up front so in_push gets one assignment per edge. in_push is left high on
  // return so back-to-back requests keep it asserted.
  task automatic send_request(input logic [15:0] addr, input logic [7:0] data);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 15) gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_bus_address <= addr;
    in_write_data  <= data;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    sb.note_request(addr, data);
    requests_sent++;
  endtask

  // Lower push, let every outstanding mapping come back, then keep idling
  // so nothing is still inside the block when the config changes.
  task automatic drain();
    in_push <= 1'b0;
    while (sb.expected_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // All six registers written back to back; the block is idle here.
  task automatic load_config(input logic [1:0] variant, input logic [7:0] prg_max,
                             input logic prg_sw, input logic [7:0] c2k_max,
                             input logic [8:0] c1k_max, input logic ram);
    logic [CFG_IDX_BITS-1:0]  ids [6];
    logic [CFG_DATA_BITS-1:0] vals [6];
    ids  = '{CFG_BOARD_VARIANT, CFG_PRG_BANK_MAX, CFG_PRG_SWITCH_EN,
             CFG_CHR_2K_MAX, CFG_CHR_1K_MAX, CFG_CHR_IS_RAM};
    vals = '{9'(variant), 9'(prg_max), 9'(prg_sw), 9'(c2k_max), c1k_max, 9'(ram)};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= ids[i];
      cfg_data  <= vals[i];
      sb.write_register(ids[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random address inside the window, with the port bits forced.
  function automatic logic [15:0] window_addr(logic [15:0] port);
    logic [15:0] a;
    a = 16'($urandom_range(WIN_LO, WIN_HI));
    return (a & ~PORT_MASK) | port;
  endfunction

  // In the window but on neither port: bit 8 clear, bit 0 either way.
  function automatic logic [15:0] stray_addr();
    logic [15:0] a;
    a = 16'($urandom_range(16'h4200, WIN_HI));
    a[8] = 1'b0;
    return a;
  endfunction

  task automatic select_index(input logic [2:0] idx);
    logic [7:0] d;
    d      = 8'($urandom);
    d[2:0] = idx;
    send_request(window_addr(PORT_INDEX), d);
  endtask

  // Mostly index-then-data pairs with random content, plus lone data writes
  // (hit whatever index is latched), lone index writes, stray window hits and
  // fully random bus addresses.
  task automatic random_requests(input int count);
    int start;
    int pick;
    start = requests_sent;
    while (requests_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        select_index(3'($urandom_range(0, 7)));
        send_request(window_addr(PORT_DATA), 8'($urandom));
      end else if (pick < 72) begin
        send_request(window_addr(PORT_DATA), 8'($urandom));
      end else if (pick < 82) begin
        select_index(3'($urandom_range(0, 7)));
      end else if (pick < 91) begin
        send_request(stray_addr(), 8'($urandom));
      end else begin
        send_request(16'($urandom), 8'($urandom));
      end
    end
  endtask

  // Directed opening under the reset config (variant A, PRG limit 0).
  task automatic directed_requests();
    send_request(16'h0000, 8'hFF);   // bottom of the bus, ignored
    send_request(16'h40FF, 8'h00);   // one below the window
    send_request(16'hFFFF, 8'hFF);   // data-port pattern but above the window
    send_request(16'h4200, 8'h05);   // window, neither port
    send_request(16'h7E01, 8'h05);   // window, only bit 0: neither port
    send_request(16'h4100, 8'hF8);   // index 0, upper data bits dropped
    send_request(16'h7FFF, 8'hFF);   // top of window, data port, reg 0
    send_request(16'h4100, 8'h04);
    send_request(16'h4101, 8'h07);   // reg 4 supplies the high CHR bits
    send_request(16'h4100, 8'h01);
    send_request(16'h4101, 8'h03);
    send_request(16'h4100, 8'h06);
    send_request(16'h4101, 8'h01);   // reg 6: not PRG or mirror, CHR recompute
    send_request(16'h4100, 8'h05);
    send_request(16'h4101, 8'hFF);   // PRG write, clamped by limit 0
    send_request(16'h4100, 8'h07);
    send_request(16'h4101, 8'h06);   // single screen
    send_request(16'h4101, 8'h03);   // bit 0 set: back to vertical
    send_request(16'h4100, 8'h02);
    send_request(16'h4101, 8'h80);   // reg 2 write; reg 7 bit 0 is set: all slots follow reg 0
    send_request(16'h4100, 8'h07);
    send_request(16'h4101, 8'h04);   // three-one screen, clears the shared flag
    send_request(16'h4101, 8'h02);   // horizontal
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_requests();
    random_requests(ITEMS_PER_PHASE - 23);
    drain();

    // Each phase reloads every register: extremes first, then random settings.
    for (int phase = 1; phase <= LAST_PHASE; phase++) begin
      case (phase)
        1: load_config(VAR_A, 8'hFF, 1'b1, 8'hFF, 9'h1FF, 1'b0);
        2: load_config(VAR_B, 8'h0F, 1'b1, 8'h3F, 9'h000, 1'b0);
        3: load_config(VAR_C, 8'hAA, 1'b0, 8'h55, 9'h1FF, 1'b1);
        4: load_config(VAR_D, 8'hFF, 1'b1, 8'h00, 9'h00A, 1'b0);
        5: load_config(VAR_D, 8'h80, 1'b1, 8'hFF, 9'h1FF, 1'b0);
        6: load_config(VAR_C, 8'h00, 1'b1, 8'h00, 9'h000, 1'b0);
        default: load_config(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                             8'($urandom), 9'($urandom), 1'($urandom_range(0, 3) == 0));
      endcase
      steady = (phase == STEADY_PHASE);
      random_requests(ITEMS_PER_PHASE);
      drain();
    end

    $display("Sent %0d CPU write requests over %0d config settings, all four variants.",
             requests_sent, LAST_PHASE + 1);
    $display("Checked %0d mapping results, %0d field mismatches.",
             sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_maps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ibm_pkg.sv
rtl/core/ibm_fifo.sv
rtl/core/ibm_front.sv
rtl/core/ibm_back.sv
rtl/core/indexed_bank_mapper_8259.sv
bench/indexed_bank_mapper_8259_test.sv
